@@ design/sha256_message_digest_top_assert.svh @@
// Assertion macros for the SHA-256 digest block
`ifndef SHA256_MESSAGE_DIGEST_TOP_ASSERT_SVH
`define SHA256_MESSAGE_DIGEST_TOP_ASSERT_SVH
// implication checked on every edge outside reset
`define SHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

@@ design/sha_pkg.sv @@
// Types, constants and round functions for the SHA-256 digest block
package sha_pkg;
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       message_end;
    } t_in_item;

    typedef struct packed {
        logic [63:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } t_out_item;

    // one block job handed from the front part to the engine
    typedef struct packed {
        logic         ends_msg;
        logic         use_224;
        logic [511:0] block;
    } t_job;

    localparam logic [255:0] IV_256 = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [255:0] IV_224 = {
        32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
        32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4};

    localparam logic [31:0] K_TAB [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction
endpackage

@@ design/sha_front.sv @@
// Front part: byte collection, padding and block job issue
module sha_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_iv_select,
    input  logic              i_valid,
    output logic              o_ready,
    input  sha_pkg::t_in_item i_item,
    output logic              o_job_valid,
    input  logic              i_job_ready,
    output sha_pkg::t_job     o_job
);
    import sha_pkg::*;

    typedef enum logic [2:0] {
        ST_COLLECT = 3'b001,
        ST_PAD     = 3'b010,
        ST_LEN     = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [511:0]  r_block, n_block;
    logic [5:0]    r_fill, n_fill;
    logic [60:0]   r_bytes, n_bytes;
    logic          r_jv, n_jv;
    logic          r_end, n_end;
    logic          r_224, n_224;
    logic          r_msg_224, n_msg_224;
    logic [511:0]  w_pad;
    logic [9:0]    w_sh;

    assign o_ready     = (r_state == ST_COLLECT) && !r_jv;
    assign o_job_valid = r_jv;
    assign o_job       = '{ends_msg: r_end, use_224: r_224, block: r_block};
    assign w_sh        = {1'b0, r_fill, 3'b000};

    // 0x80 at the fill position, zeros after it
    always_comb begin
        w_pad = (r_block & ~({512{1'b1}} >> w_sh)) | ({8'h80, 504'd0} >> w_sh);
    end

    always_comb begin
        n_state   = r_state;
        n_block   = r_block;
        n_fill    = r_fill;
        n_bytes   = r_bytes;
        n_jv      = r_jv;
        n_end     = r_end;
        n_224     = r_224;
        n_msg_224 = r_msg_224;
        // follow register writes until the message has its first byte
        if (r_state == ST_COLLECT && r_bytes == '0 && r_fill == '0) begin
            n_msg_224 = i_iv_select;
        end
        if (r_jv && i_job_ready) begin
            n_jv = 1'b0;
        end
        case (r_state)
            ST_COLLECT: begin
                if (i_valid && o_ready) begin
                    if (i_item.byte_valid) begin
                        n_block = (r_block & ~({8'hff, 504'd0} >> w_sh))
                                | ({i_item.data_byte, 504'd0} >> w_sh);
                        n_fill  = r_fill + 6'd1;
                        n_bytes = r_bytes + 61'd1;
                        if (r_fill == 6'd63) begin
                            n_jv  = 1'b1;
                            n_end = 1'b0;
                            n_224 = r_msg_224;
                        end
                    end
                    if (i_item.message_end) begin
                        n_state = (i_item.byte_valid && r_fill == 6'd63) ? ST_LEN : ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                if (!r_jv) begin
                    if (r_fill >= 6'd56) begin
                        n_block = w_pad;
                        n_jv    = 1'b1;
                        n_end   = 1'b0;
                        n_224   = r_msg_224;
                        n_state = ST_LEN;
                    end else begin
                        n_block = {w_pad[511:64], r_bytes, 3'b000};
                        n_jv    = 1'b1;
                        n_end   = 1'b1;
                        n_224   = r_msg_224;
                        n_state = ST_COLLECT;
                        n_fill  = '0;
                        n_bytes = '0;
                    end
                end
            end
            ST_LEN: begin
                if (!r_jv) begin
                    n_block = {448'd0, r_bytes, 3'b000};
                    if (r_fill == 6'd0) begin
                        n_block[511:504] = 8'h80;
                    end
                    n_jv    = 1'b1;
                    n_end   = 1'b1;
                    n_224   = r_msg_224;
                    n_state = ST_COLLECT;
                    n_fill  = '0;
                    n_bytes = '0;
                end
            end
            default: n_state = ST_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_COLLECT;
            r_fill    <= '0;
            r_bytes   <= '0;
            r_jv      <= 1'b0;
            r_end     <= 1'b0;
            r_224     <= 1'b0;
            r_msg_224 <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_bytes   <= n_bytes;
            r_jv      <= n_jv;
            r_end     <= n_end;
            r_224     <= n_224;
            r_msg_224 <= n_msg_224;
        end
        r_block <= n_block;
    end
endmodule

@@ design/sha_engine.sv @@
// Back part: 64-round compression, chaining state and digest output
module sha_engine (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_iv_select,
    input  logic               i_job_valid,
    output logic               o_job_ready,
    input  sha_pkg::t_job      i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_item o_item
);
    import sha_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_ADD   = 4'b0100,
        ST_OUT   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [255:0]  r_cv, n_cv;
    logic [255:0]  r_s, n_s;
    logic [511:0]  r_w, n_w;
    logic [5:0]    r_rnd, n_rnd;
    logic [1:0]    r_idx, n_idx;
    logic          r_end, n_end;
    logic          r_fresh, n_fresh;
    logic [255:0]  w_base;
    logic [31:0]   w_new, w_t1, w_t2, w15, w2;
    logic [31:0]   a, b, c, d, e, f, g, h;

    assign o_job_ready = (r_state == ST_IDLE);
    assign o_valid     = (r_state == ST_OUT);
    assign o_item      = '{digest_word: r_cv[255 - 64 * r_idx -: 64],
                           word_index: r_idx, last_word: (r_idx == 2'd3)};

    // fresh message starts from the IV latched when the message took its first byte
    assign w_base = r_fresh ? (i_job.use_224 ? IV_224 : IV_256) : r_cv;

    assign {a, b, c, d, e, f, g, h} = r_s;
    assign w15 = r_w[479:448];
    assign w2  = r_w[63:32];
    assign w_new = r_w[511:480] + r_w[223:192]
                 + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3))
                 + (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10));
    assign w_t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                + K_TAB[r_rnd] + r_w[511:480];
    assign w_t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));

    always_comb begin
        n_state = r_state;
        n_cv    = r_cv;
        n_s     = r_s;
        n_w     = r_w;
        n_rnd   = r_rnd;
        n_idx   = r_idx;
        n_end   = r_end;
        n_fresh = r_fresh;
        case (r_state)
            ST_IDLE: begin
                if (r_fresh) begin
                    // follow register writes while idle between messages
                    n_cv = i_iv_select ? IV_224 : IV_256;
                end
                if (i_job_valid) begin
                    n_cv    = w_base;
                    n_s     = w_base;
                    n_w     = i_job.block;
                    n_end   = i_job.ends_msg;
                    n_rnd   = '0;
                    n_fresh = 1'b0;
                    n_state = ST_ROUND;
                end
            end
            ST_ROUND: begin
                n_s   = {w_t1 + w_t2, a, b, c, d + w_t1, e, f, g};
                n_w   = {r_w[479:0], w_new};
                n_rnd = r_rnd + 6'd1;
                if (r_rnd == 6'd63) begin
                    n_state = ST_ADD;
                end
            end
            ST_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    n_cv[32 * i +: 32] = r_cv[32 * i +: 32] + r_s[32 * i +: 32];
                end
                n_idx   = '0;
                n_state = r_end ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (i_ready) begin
                    n_idx = r_idx + 2'd1;
                    if (r_idx == 2'd3) begin
                        n_fresh = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fresh <= 1'b1;
            r_idx   <= '0;
            r_rnd   <= '0;
            r_end   <= 1'b0;
            r_cv    <= IV_256;
        end else begin
            r_state <= n_state;
            r_fresh <= n_fresh;
            r_idx   <= n_idx;
            r_rnd   <= n_rnd;
            r_end   <= n_end;
            r_cv    <= n_cv;
        end
        r_s <= n_s;
        r_w <= n_w;
    end
endmodule

@@ design/sha256_message_digest_top.sv @@
// SHA-256 digest block: byte front end feeding a round-serial compression engine
// Bytes transfer at one per cycle; a full block or message end stalls input till drained.
// Each block passes through the engine as a load, 64 rounds and a chaining add.
// A message end adds one or two padding blocks, then four digest transfers.
// Synchronous active-low reset loads the SHA-256 initial values and empties all counts.
module sha256_message_digest_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_ready,
    input  sha_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output sha_pkg::t_out_item o_data
);
    import sha_pkg::*;

    logic  r_iv_select;
    logic  w_job_valid, w_job_ready;
    t_job  w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv_select <= 1'b0;
        end else if (i_cfg_we) begin
            r_iv_select <= i_cfg_wdata;
        end
    end

    sha_front u_front (
        .i_clk, .i_rst_n, .i_iv_select(r_iv_select),
        .i_valid, .o_ready, .i_item(i_data),
        .o_job_valid(w_job_valid), .i_job_ready(w_job_ready), .o_job(w_job)
    );

    sha_engine u_engine (
        .i_clk, .i_rst_n, .i_iv_select(r_iv_select),
        .i_job_valid(w_job_valid), .o_job_ready(w_job_ready), .i_job(w_job),
        .o_valid, .i_ready, .o_item(o_data)
    );
endmodule

@@ design/sha_checker.sv @@
// Port-level checker for the SHA-256 digest block, with its bind
`include "sha256_message_digest_top_assert.svh"
module sha_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_ready,
    input sha_pkg::t_out_item o_data
);
    import sha_pkg::*;

    `SHA_ASSERT_IMPL(a_last_idx, i_clk, i_rst_n, o_valid, o_data.last_word == (o_data.word_index == 2'd3))
    `SHA_ASSERT_NEXT(a_idx_step, i_clk, i_rst_n, o_valid && i_ready && !o_data.last_word, o_valid && o_data.word_index == $past(o_data.word_index) + 2'd1)
    `SHA_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_data))
endmodule

bind sha256_message_digest_top sha_checker u_sha_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data)
);

@@ dv/sha256_message_digest_top_test.sv @@
// Self-checking testbench for the byte-serial SHA-256/224 digest block
module sha256_message_digest_top_test;
    import sha_pkg::*;

    localparam int IDLE_PCT = 16;
    localparam int TAIL_CYCLES = 400;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    logic      i_cfg_wdata;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    sha256_message_digest_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

    // predictor state
    logic        iv_sel;
    logic [31:0] hash_state [8];
    logic [7:0]  block_buf [64];
    logic [5:0]  fill;
    logic [60:0] msg_len;

    t_out_item digest_q [$];
    int        err_count;
    int        word_count;
    int        msg_count;
    bit        no_idle;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [31:0] ror(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void load_iv();
        logic [255:0] iv;
        iv = iv_sel ? IV_224 : IV_256;
        for (int k = 0; k < 8; k++) hash_state[k] = iv[255 - 32 * k -: 32];
    endfunction

    function automatic void compress_block();
        logic [31:0] w [16];
        logic [31:0] s [8];
        logic [31:0] wt, t1, t2, a15, a2;
        for (int t = 0; t < 16; t++)
            w[t] = {block_buf[4 * t], block_buf[4 * t + 1], block_buf[4 * t + 2],
                    block_buf[4 * t + 3]};
        for (int k = 0; k < 8; k++) s[k] = hash_state[k];
        for (int t = 0; t < 64; t++) begin
            if (t < 16) begin
                wt = w[t];
            end else begin
                a15 = w[(t - 15) & 15];
                a2 = w[(t - 2) & 15];
                wt = w[t & 15] + w[(t - 7) & 15]
                   + (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3))
                   + (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10));
                w[t & 15] = wt;
            end
            t1 = s[7] + (ror(s[4], 6) ^ ror(s[4], 11) ^ ror(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + K_TAB[t] + wt;
            t2 = (ror(s[0], 2) ^ ror(s[0], 13) ^ ror(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int k = 0; k < 8; k++) hash_state[k] += s[k];
    endfunction

    function automatic void predict_digest(input t_in_item it);
        logic [63:0] bits;
        t_out_item   d;
        if (it.byte_valid) begin
            block_buf[fill] = it.data_byte;
            fill = fill + 6'd1;
            msg_len = msg_len + 61'd1;
            if (fill == 0) compress_block();
        end
        if (!it.message_end) return;
        block_buf[fill] = 8'h80;
        for (int k = fill + 1; k < 64; k++) block_buf[k] = 8'h00;
        if (fill >= 56) begin
            compress_block();
            for (int k = 0; k < 64; k++) block_buf[k] = 8'h00;
        end
        bits = {msg_len, 3'b000};
        for (int k = 0; k < 8; k++) block_buf[56 + k] = bits[63 - 8 * k -: 8];
        compress_block();
        for (int k = 0; k < 4; k++) begin
            d.digest_word = {hash_state[2 * k], hash_state[2 * k + 1]};
            d.word_index = k[1:0];
            d.last_word = (k == 3);
            digest_q.push_back(d);
        end
        load_iv();
        fill = '0;
        msg_len = '0;
        msg_count++;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // valid stays up into the next item unless an idle cycle comes between
    task automatic send_item(input logic [7:0] b, input logic v, input logic e);
        while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data <= '{data_byte: b, byte_valid: v, message_end: e};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_digest('{data_byte: b, byte_valid: v, message_end: e});
    endtask

    // wait for all digests, then let the engine settle before a register write
    task automatic drain_and_set_iv(input logic sel);
        i_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= sel;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        iv_sel = sel;
        if (msg_len == 0 && fill == 0) load_iv();
    endtask

    task automatic send_message(input int len);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, 1'b0);
        end
        send_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);                  // empty message
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);                  // "abc" with last byte on end
        send_item(8'hff, 1'b0, 1'b0);                  // ignored byte
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b1);                  // end with invalid byte
        for (int k = 0; k < 55; k++) send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b1);                  // 56 bytes: padding spills
    endtask

    task automatic test_boundaries();
        int lens [2] = '{55, 63};
        foreach (lens[i]) send_message(lens[i]);
    endtask

    task automatic test_iv_select();
        drain_and_set_iv(1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_message(3);
        send_item(8'h12, 1'b1, 1'b0);
        drain_and_set_iv(1'b0);                        // takes effect after this message
        send_item(8'h34, 1'b1, 1'b1);
        send_message(10);
        drain_and_set_iv(1'b1);
        drain_and_set_iv(1'b0);
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        while (sent < 100) begin
            int len;
            len = ($urandom_range(9) == 0) ? $urandom_range(130) : $urandom_range(20);
            no_idle = (sent > 30 && sent < 80);
            if ($urandom_range(7) == 0) drain_and_set_iv(1'($urandom_range(1)));
            send_message(len);
            sent += len + 1;
        end
        no_idle = 1'b0;
    endtask

    // digest checker and output stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (digest_q.size() == 0) begin
                    report_mismatch("unexpected word", o_data.digest_word, '0);
                end else begin
                    t_out_item w;
                    w = digest_q.pop_front();
                    if (o_data.digest_word !== w.digest_word)
                        report_mismatch("digest_word", o_data.digest_word, w.digest_word);
                    if (o_data.word_index !== w.word_index)
                        report_mismatch("word_index", o_data.word_index, w.word_index);
                    if (o_data.last_word !== w.last_word)
                        report_mismatch("last_word", o_data.last_word, w.last_word);
                    word_count++;
                end
            end
            i_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_ready = 1'b0;
        err_count = 0;
        word_count = 0;
        msg_count = 0;
        no_idle = 1'b0;
        iv_sel = 1'b0;
        fill = '0;
        msg_len = '0;
        load_iv();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_boundaries();
        test_iv_select();
        test_random();

        i_valid <= 1'b0;
        while (digest_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Hashed %0d messages under both initial-value sets, %0d digest words checked",
                 msg_count, word_count);
        if (err_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
